// File: src/cgbf_pkg.sv
// Shared types and constants for the circular grid Bayes filter.
// No dependencies; used by cgbf_div and the top level.
package cgbf_pkg;

  localparam int Q_W     = 16;  // Q0.16 probability / belief width
  localparam int LIK_W   = 17;  // likelihood, up to 65536
  localparam int ACC_W   = 34;  // sum of three 16x16 products
  localparam int MOVE_W  = 7;
  localparam int CELL_W  = 6;
  localparam int MAP_W   = 64;
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_EXACT  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_UNDER  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_OVER   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DETECT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FALSE  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_MAP    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PRED,
    ST_NRD,
    ST_NLD,
    ST_DIV,
    ST_MUL,
    ST_WB
  } state_t;

endpackage

// File: src/cgbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cgbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cgbf_div.sv
// Restoring divider: q = min(floor(a * 65536 / s), 65535), one bit per cycle.
// Requires a <= s and s != 0. Depends on cgbf_pkg.
module cgbf_div #(
  parameter int SUM_W = 39
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cgbf_pkg::ACC_W-1:0]  a,
  input  logic [SUM_W-1:0]            s,
  output logic                        done,
  output logic [cgbf_pkg::Q_W-1:0]    q
);

  logic             busy;
  logic [4:0]       cnt;
  logic [SUM_W:0]   rem;
  logic [SUM_W:0]   trial;
  logic             bit_set;
  logic [16:0]      quo;

  // first step compares the plain numerator, later steps shift it up
  assign trial   = (cnt == 5'd16) ? rem : {rem[SUM_W-1:0], 1'b0};
  assign bit_set = trial >= {1'b0, s};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        rem  <= (SUM_W+1)'(a);
        quo  <= '0;
      end else if (busy) begin
        rem <= bit_set ? trial - {1'b0, s} : trial;
        quo <= {quo[15:0], bit_set};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign q = quo[16] ? 16'hFFFF : quo[15:0];

endmodule

// File: src/circular_grid_bayes_filter.sv
// Histogram Bayes filter over a circular grid; top level.
// Depends on cgbf_pkg, cgbf_ram and cgbf_div.
//
// The block keeps one Q0.16 belief per cell of a ring of NUM_CELLS cells,
// uniform after reset. Each request (a signed move and a landmark sensor bit)
// runs a motion prediction spreading every belief to the target cell and its
// two neighbors, normalizes, multiplies by the landmark likelihood picked from
// mark_map, normalizes again, and streams all cells out, cell 0 first, tlast
// on the last one. Requests are handled one at a time; s_tready is high only
// while the block is idle. A request is accepted in the idle state, then the
// move is reduced one step of N per cycle plus a final one, the prediction
// works through five steps per cell on the single read port of the belief
// RAM, and each of the two normalization passes runs the bit-serial divider
// once per cell. A pass whose total is zero skips the divider. A stalled
// output stalls the second pass. No clearing pass is needed after reset: the
// uniform start value is supplied on reads until the first request rewrites
// the RAM.
// Write configuration only while idle with no request in flight.
module circular_grid_bayes_filter #(
  parameter int NUM_CELLS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // request: [6:0] move_cells (signed), [7] sensed_mark
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // result: [5:0] cell_res, [21:6] weight, [23:22] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int IW    = $clog2(NUM_CELLS);
  localparam int SUM_W = cgbf_pkg::ACC_W + IW;
  localparam int UNI_R = 65536 / NUM_CELLS;
  localparam logic [cgbf_pkg::Q_W-1:0] UNIFORM =
    (UNI_R > 65535) ? 16'hFFFF : cgbf_pkg::Q_W'(UNI_R);
  localparam logic [IW-1:0]     LAST_CELL = IW'(NUM_CELLS - 1);
  localparam logic signed [7:0] NC8       = 8'(NUM_CELLS);

  // configuration registers
  logic [15:0] p_exact, p_under, p_over, p_detect, p_false;
  logic [63:0] mark_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_exact  <= 16'd52429;
      p_under  <= 16'd6554;
      p_over   <= 16'd6554;
      p_detect <= 16'd58982;
      p_false  <= 16'd6554;
      mark_map <= 64'd16392;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgbf_pkg::REG_EXACT:  p_exact  <= cfg_data[15:0];
        cgbf_pkg::REG_UNDER:  p_under  <= cfg_data[15:0];
        cgbf_pkg::REG_OVER:   p_over   <= cfg_data[15:0];
        cgbf_pkg::REG_DETECT: p_detect <= cfg_data[15:0];
        cgbf_pkg::REG_FALSE:  p_false  <= cfg_data[15:0];
        cgbf_pkg::REG_MAP:    mark_map <= cfg_data;
        default: ;
      endcase
    end
  end

  cgbf_pkg::state_t state, state_next;

  logic                      bel_init;   // belief RAM holds real data
  logic                      pass;       // 0: predicted pass, 1: posterior pass
  logic                      sensed;
  logic signed [7:0]         rr;         // move being reduced modulo N
  logic [IW-1:0]             shift;
  logic [IW-1:0]             cur_cell;
  logic [2:0]                ps;         // prediction step within a cell
  logic [cgbf_pkg::ACC_W-1:0] acc_cur, prod;
  logic [SUM_W-1:0]          sum_acc, div_sum;
  logic [cgbf_pkg::Q_W-1:0]  qv;

  logic mod_done, cell_last, out_free;
  assign mod_done  = (rr >= 0) && (rr < NC8);
  assign cell_last = (cur_cell == LAST_CELL);
  assign out_free  = !m_tvalid || m_tready;

  // RAM ports
  logic                          bel_we, acc_we;
  logic [IW-1:0]                 bel_raddr;
  logic [cgbf_pkg::Q_W-1:0]      bel_q, bel_rd;
  logic [cgbf_pkg::ACC_W-1:0]    acc_wdata, acc_q;

  // divider
  logic                     div_start, div_done;
  logic [cgbf_pkg::Q_W-1:0] div_q;

  // source cell of the current tap: exact i-r, under i-r+1, over i-r-1
  logic signed [7:0] src_raw, src_fix;
  always_comb begin
    priority case (ps)
      3'd1:    src_raw = 8'(cur_cell) - 8'(shift) + 8'sd1;
      3'd2:    src_raw = 8'(cur_cell) - 8'(shift) - 8'sd1;
      default: src_raw = 8'(cur_cell) - 8'(shift);
    endcase
    if (src_raw < 0) begin
      src_fix = src_raw + NC8;
    end else if (src_raw >= NC8) begin
      src_fix = src_raw - NC8;
    end else begin
      src_fix = src_raw;
    end
    bel_raddr = src_fix[IW-1:0];
  end

  assign bel_rd = bel_init ? bel_q : UNIFORM;

  // tap weight matching the data arriving in this step
  logic [15:0] w_sel;
  always_comb begin
    priority case (ps)
      3'd1:    w_sel = p_exact;
      3'd2:    w_sel = p_under;
      default: w_sel = p_over;
    endcase
  end

  // landmark likelihood of the current cell
  logic        mark_bit;
  logic [16:0] lik;
  assign mark_bit = mark_map[6'(cur_cell)];
  assign lik = sensed ? {1'b0, (mark_bit ? p_detect : p_false)}
                      : 17'h10000 - {1'b0, (mark_bit ? p_detect : p_false)};

  assign bel_we    = (state == cgbf_pkg::ST_WB) && pass && out_free;
  assign acc_we    = ((state == cgbf_pkg::ST_PRED) && (ps == 3'd4)) ||
                     ((state == cgbf_pkg::ST_WB) && !pass);
  assign acc_wdata = (state == cgbf_pkg::ST_PRED) ? acc_cur + prod : prod;
  assign div_start = (state == cgbf_pkg::ST_NLD) && (div_sum != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cgbf_pkg::ST_IDLE: if (s_tvalid) state_next = cgbf_pkg::ST_MOD;
      cgbf_pkg::ST_MOD:  if (mod_done) state_next = cgbf_pkg::ST_PRED;
      cgbf_pkg::ST_PRED: if (ps == 3'd4 && cell_last) state_next = cgbf_pkg::ST_NRD;
      cgbf_pkg::ST_NRD:  state_next = cgbf_pkg::ST_NLD;
      cgbf_pkg::ST_NLD: begin
        if (div_sum != '0) begin
          state_next = cgbf_pkg::ST_DIV;
        end else begin
          state_next = pass ? cgbf_pkg::ST_WB : cgbf_pkg::ST_MUL;
        end
      end
      cgbf_pkg::ST_DIV: begin
        if (div_done) state_next = pass ? cgbf_pkg::ST_WB : cgbf_pkg::ST_MUL;
      end
      cgbf_pkg::ST_MUL:  state_next = cgbf_pkg::ST_WB;
      cgbf_pkg::ST_WB: begin
        if (!pass) begin
          state_next = cgbf_pkg::ST_NRD;
        end else if (out_free) begin
          state_next = cell_last ? cgbf_pkg::ST_IDLE : cgbf_pkg::ST_NRD;
        end
      end
      default: state_next = cgbf_pkg::ST_IDLE;
    endcase
  end

  assign s_tready = (state == cgbf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bel_init <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (bel_we) begin
        m_tvalid <= 1'b1;
        if (cell_last) bel_init <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      cgbf_pkg::ST_IDLE: begin
        rr       <= 8'(signed'(s_tdata[6:0]));
        sensed   <= s_tdata[7];
        cur_cell <= '0;
        ps       <= '0;
        pass     <= 1'b0;
        acc_cur  <= '0;
        sum_acc  <= '0;
      end
      cgbf_pkg::ST_MOD: begin
        // wrap the move one step of N per cycle
        if (rr < 0) begin
          rr <= rr + NC8;
        end else if (rr >= NC8) begin
          rr <= rr - NC8;
        end
        shift <= rr[IW-1:0];
      end
      cgbf_pkg::ST_PRED: begin
        if (ps >= 3'd1 && ps <= 3'd3) begin
          prod <= cgbf_pkg::ACC_W'(w_sel) * cgbf_pkg::ACC_W'(bel_rd);
        end
        if (ps == 3'd2 || ps == 3'd3) begin
          acc_cur <= acc_cur + prod;
        end
        if (ps == 3'd4) begin
          ps      <= '0;
          acc_cur <= '0;
          if (cell_last) begin
            div_sum  <= sum_acc + SUM_W'(acc_cur + prod);
            sum_acc  <= '0;
            cur_cell <= '0;
          end else begin
            sum_acc  <= sum_acc + SUM_W'(acc_cur + prod);
            cur_cell <= cur_cell + 1'b1;
          end
        end else begin
          ps <= ps + 3'd1;
        end
      end
      cgbf_pkg::ST_NLD: begin
        if (div_sum == '0) qv <= UNIFORM;
      end
      cgbf_pkg::ST_DIV: begin
        if (div_done) qv <= div_q;
      end
      cgbf_pkg::ST_MUL: begin
        prod <= cgbf_pkg::ACC_W'(lik) * cgbf_pkg::ACC_W'(qv);
      end
      cgbf_pkg::ST_WB: begin
        if (!pass) begin
          if (cell_last) begin
            div_sum  <= sum_acc + SUM_W'(prod);
            sum_acc  <= '0;
            cur_cell <= '0;
            pass     <= 1'b1;
          end else begin
            sum_acc  <= sum_acc + SUM_W'(prod);
            cur_cell <= cur_cell + 1'b1;
          end
        end else if (out_free) begin
          m_tdata  <= {2'b00, qv, cgbf_pkg::CELL_W'(cur_cell)};
          m_tlast  <= cell_last;
          cur_cell <= cur_cell + 1'b1;
        end
      end
      default: ;
    endcase
  end

  cgbf_ram #(.WIDTH(cgbf_pkg::Q_W), .DEPTH(NUM_CELLS)) u_bel_ram (
    .clk   (clk),
    .we    (bel_we),
    .waddr (cur_cell),
    .wdata (qv),
    .raddr (bel_raddr),
    .rdata (bel_q)
  );

  cgbf_ram #(.WIDTH(cgbf_pkg::ACC_W), .DEPTH(NUM_CELLS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (cur_cell),
    .wdata (acc_wdata),
    .raddr (cur_cell),
    .rdata (acc_q)
  );

  cgbf_div #(.SUM_W(SUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (acc_q),
    .s     (div_sum),
    .done  (div_done),
    .q     (div_q)
  );

  // accepted request starts the move reduction
  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == cgbf_pkg::ST_MOD)
    else $error("request accepted but sequencer did not start");

  // divider finishes only while the sequencer waits for it
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == cgbf_pkg::ST_DIV)
    else $error("divider result with no division pending");

  // last emitted cell returns the block to idle
  a_last: assert property (@(posedge clk) disable iff (rst)
    bel_we && cell_last |=> state == cgbf_pkg::ST_IDLE && m_tvalid && m_tlast)
    else $error("last cell did not end the request");

  // tlast marks the highest cell index
  a_tlast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(NUM_CELLS - 1))
    else $error("tlast on wrong cell");

endmodule
